// ===== sv/shim_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// shim_pkg
// Shared types, constants and the contig close function of the sorted hit
// interval merger.
// ----------------------------------------------------------------------------
package shim_pkg;

    localparam int NUM_TABLES = 64;
    localparam logic [6:0] NUM_TABLES_C = 7'(NUM_TABLES);

    // configuration register indexes
    localparam logic [1:0] CFG_MAX_CONTIG_LEN = 2'd0;
    localparam logic [1:0] CFG_MIN_HITS       = 2'd1;
    localparam logic [1:0] CFG_BEST_DISTANCE  = 2'd2;
    localparam logic [1:0] CFG_PADDING        = 2'd3;

    typedef struct packed {
        logic [31:0] max_contig_len;
        logic [6:0]  min_hits;
        logic [6:0]  best_distance;
        logic [15:0] padding;
    } shim_cfg_t;

    typedef struct packed {
        logic [31:0] hit_pos;
        logic [15:0] hit_len;
        logic [5:0]  table_id;
        logic        strand;
        logic [15:0] read_len;
        logic        new_read;
        logic        last_hit;
    } shim_in_t;

    typedef struct packed {
        logic [31:0] contig_start;
        logic [31:0] contig_len;
        logic [6:0]  hit_count;
        logic        contig_strand;
        logic        passed;
        logic        last;
    } shim_out_t;

    // results caused by one hit: one, or two when two contigs close
    typedef struct packed {
        logic      two;
        shim_out_t first;
        shim_out_t second;
    } shim_pair_t;

    typedef struct packed {
        shim_out_t  res;
        logic [6:0] best;
    } shim_close_t;

    // Filter a closing contig, raise the best count and build its padded result.
    function automatic shim_close_t shim_close(
        input logic [31:0] span,
        input logic [31:0] cend,
        input logic [6:0]  n,
        input logic [6:0]  best,
        input shim_cfg_t   cfg,
        input logic        strand,
        input logic [15:0] read_len
    );
        logic        pass;
        logic [33:0] d;
        logic [33:0] ds;
        logic [33:0] lsum;
        shim_close_t r;
        pass = !(span > cfg.max_contig_len) && !(n < cfg.min_hits)
            && !(({1'b0, n} + {1'b0, cfg.best_distance}) < {1'b0, best});
        r.best = (pass && (n > best)) ? n : best;
        d = {2'b0, cend} - {2'b0, span} + 34'd1;
        ds = d - {18'b0, cfg.padding};
        if (d[33]) begin
            r.res.contig_start = '1;
        end else if (d >= {18'b0, cfg.padding}) begin
            r.res.contig_start = ds[32] ? '1 : ds[31:0];
        end else begin
            r.res.contig_start = '0;
        end
        lsum = {2'b0, span} + {17'b0, cfg.padding, 1'b0} + {18'b0, read_len};
        r.res.contig_len    = (lsum[33:32] != 2'b00) ? '1 : lsum[31:0];
        r.res.hit_count     = n;
        r.res.contig_strand = strand;
        r.res.passed        = pass;
        r.res.last          = 1'b0;
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== sv/shim_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// shim_core
// Open-contig state, hit merge, table bitmap and contig close for each
// accepted hit; the results of a hit leave as one pair record.
// ----------------------------------------------------------------------------
module shim_core
    import shim_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       accept,
    input  wire shim_in_t   hit,
    input  wire shim_cfg_t  cfg,
    output logic            has_res,
    output shim_pair_t      pair
);

    logic        open_reg, open_next;
    logic [31:0] end_reg, end_next;
    logic [31:0] span_reg, span_next;
    logic [6:0]  dist_reg, dist_next;
    logic [63:0] seen_reg, seen_next;
    logic [6:0]  best_reg, best_next;

    logic [15:0] lm1;
    logic [32:0] end_sum;
    logic [31:0] hit_end;
    logic [31:0] grow;
    logic [32:0] span_sum;
    logic [6:0]  best0;
    logic        merge;
    logic        tid_ok;
    logic [63:0] tid_bit;
    logic        close1;
    logic [31:0] span_mid;
    logic [31:0] end_mid;
    logic [6:0]  dist_mid;
    logic [63:0] seen_mid;
    shim_close_t c1;
    shim_close_t c2;
    logic [6:0]  best1;

    always_comb begin
        lm1      = (hit.hit_len != 16'd0) ? hit.hit_len - 16'd1 : 16'd0;
        end_sum  = {1'b0, hit.hit_pos} + {17'b0, lm1};
        hit_end  = end_sum[32] ? '1 : end_sum[31:0];
        best0    = hit.new_read ? 7'd0 : best_reg;
        merge    = open_reg && (hit.hit_pos <= end_reg);
        tid_ok   = {1'b0, hit.table_id} < NUM_TABLES_C;
        tid_bit  = tid_ok ? (64'd1 << hit.table_id) : 64'd0;
        grow     = hit_end - end_reg;
        span_sum = {1'b0, span_reg} + {1'b0, grow};
        close1   = open_reg && !merge;

        if (merge) begin
            if (end_reg < hit_end) begin
                span_mid = span_sum[32] ? '1 : span_sum[31:0];
                end_mid  = hit_end;
            end else begin
                span_mid = span_reg;
                end_mid  = end_reg;
            end
            dist_mid = dist_reg + {6'b0, (tid_ok && !seen_reg[hit.table_id])};
            seen_mid = seen_reg | tid_bit;
        end else begin
            span_mid = {16'b0, lm1};
            end_mid  = hit_end;
            dist_mid = {6'b0, tid_ok};
            seen_mid = tid_bit;
        end

        c1    = shim_close(span_reg, end_reg, dist_reg, best0, cfg,
                           hit.strand, hit.read_len);
        best1 = close1 ? c1.best : best0;
        c2    = shim_close(span_mid, end_mid, dist_mid, best1, cfg,
                           hit.strand, hit.read_len);

        has_res     = close1 || hit.last_hit;
        pair.two    = close1 && hit.last_hit;
        pair.first  = close1 ? c1.res : c2.res;
        pair.first.last = !(close1 && hit.last_hit);
        pair.second = c2.res;
        pair.second.last = 1'b1;

        best_next = hit.last_hit ? c2.best : best1;
        if (hit.last_hit) begin
            open_next = 1'b0;
            end_next  = '0;
            span_next = '0;
            dist_next = '0;
            seen_next = '0;
        end else begin
            open_next = 1'b1;
            end_next  = end_mid;
            span_next = span_mid;
            dist_next = dist_mid;
            seen_next = seen_mid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            open_reg <= 1'b0;
            end_reg  <= '0;
            span_reg <= '0;
            dist_reg <= '0;
            seen_reg <= '0;
            best_reg <= '0;
        end else if (accept) begin
            open_reg <= open_next;
            end_reg  <= end_next;
            span_reg <= span_next;
            dist_reg <= dist_next;
            seen_reg <= seen_next;
            best_reg <= best_next;
        end
    end

endmodule
`default_nettype wire

// ===== sv/shim_out_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// shim_out_queue
// Two-slot result queue: a head slot that drives the result channel and a
// skid slot, each holding the one or two results of a hit.
// ----------------------------------------------------------------------------
module shim_out_queue
    import shim_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       push,
    input  wire shim_pair_t push_pair,
    output logic            in_ready,
    output logic            m_valid,
    input  wire logic       m_ready,
    output shim_out_t       m_data
);

    shim_pair_t head_reg, head_next;
    shim_pair_t tail_reg, tail_next;
    logic       head_valid_reg, head_valid_next;
    logic       tail_valid_reg, tail_valid_next;
    logic       idx_reg, idx_next;
    logic       pop;
    logic       head_done;
    logic       head_free;

    assign in_ready = !tail_valid_reg;
    assign m_valid  = head_valid_reg;
    assign m_data   = idx_reg ? head_reg.second : head_reg.first;

    always_comb begin
        pop       = head_valid_reg && m_ready;
        head_done = pop && (!head_reg.two || idx_reg);
        head_free = !head_valid_reg || head_done;

        head_next       = head_reg;
        head_valid_next = head_valid_reg;
        tail_next       = tail_reg;
        tail_valid_next = tail_valid_reg;
        idx_next        = idx_reg;

        if (head_free) begin
            idx_next = 1'b0;
            if (tail_valid_reg) begin
                // advance the skid slot; no push can arrive while it is full
                head_next       = tail_reg;
                head_valid_next = 1'b1;
                tail_valid_next = 1'b0;
            end else if (push) begin
                head_next       = push_pair;
                head_valid_next = 1'b1;
            end else begin
                head_valid_next = 1'b0;
            end
        end else begin
            if (pop) begin
                idx_next = 1'b1;
            end
            if (push) begin
                tail_next       = push_pair;
                tail_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_valid_reg <= 1'b0;
            tail_valid_reg <= 1'b0;
            idx_reg        <= 1'b0;
        end else begin
            head_valid_reg <= head_valid_next;
            tail_valid_reg <= tail_valid_next;
            idx_reg        <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        head_reg <= head_next;
        tail_reg <= tail_next;
    end

endmodule
`default_nettype wire

// ===== sv/sorted_hit_interval_merger_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_hit_interval_merger_top
// Merges position-sorted hits into contigs, counts distinct tables per
// contig, filters closed contigs and emits padded contig records.
// ----------------------------------------------------------------------------
// Output path: the results of the hit that closes a contig are registered in
// the queue's head slot (its skid slot while the head is busy) for m_data.
// Throughput: one hit per cycle, set by the combinational merge/close logic,
// while s_ready is high; a hit closing two contigs sends two results in turn.
// Reset (aresetn low, synchronous): no contig open, best count and bitmap
// cleared, queue empty, registers at their defaults.
// ----------------------------------------------------------------------------
module sorted_hit_interval_merger_top
    import shim_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire shim_in_t    s_data,
    output logic             m_valid,
    input  wire logic        m_ready,
    output shim_out_t        m_data,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_wdata
);

    shim_cfg_t  cfg_reg;
    logic       accept;
    logic       has_res;
    shim_pair_t pair;

    assign accept = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.max_contig_len <= '1;
            cfg_reg.min_hits       <= 7'd1;
            cfg_reg.best_distance  <= 7'd64;
            cfg_reg.padding        <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_MAX_CONTIG_LEN: cfg_reg.max_contig_len <= cfg_wdata;
                CFG_MIN_HITS:       cfg_reg.min_hits       <= cfg_wdata[6:0];
                CFG_BEST_DISTANCE:  cfg_reg.best_distance  <= cfg_wdata[6:0];
                CFG_PADDING:        cfg_reg.padding        <= cfg_wdata[15:0];
                default: begin
                end
            endcase
        end
    end

    shim_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (accept),
        .hit     (s_data),
        .cfg     (cfg_reg),
        .has_res (has_res),
        .pair    (pair)
    );

    shim_out_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (accept && has_res),
        .push_pair (pair),
        .in_ready  (s_ready),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the sorted hit interval merger. A queue of hit
// passes (directed corner cases, then random sorted passes mixed with noise)
// feeds a valid/ready driver. Accepted hits run through a behavioral contig
// merger kept in this file, and each emitted contig record is checked field
// by field against it. Register settings change between phases while idle.
// ----------------------------------------------------------------------------
module testbench;
    import shim_pkg::*;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int LONG_HOLD      = 200;
    localparam int PHASE_ITEMS    = 155;

    logic        aclk;
    logic        aresetn   = 1'b0;
    logic        s_valid   = 1'b0;
    logic        s_ready;
    shim_in_t    s_data    = '0;
    logic        m_valid;
    logic        m_ready   = 1'b0;
    shim_out_t   m_data;
    logic        cfg_we    = 1'b0;
    logic [1:0]  cfg_index = CFG_MAX_CONTIG_LEN;
    logic [31:0] cfg_wdata = '0;

    // register copies used for prediction
    logic [31:0] max_len_q   = '1;
    logic [6:0]  min_hits_q  = 7'd1;
    logic [6:0]  best_dist_q = 7'd64;
    logic [15:0] pad_q       = '0;

    // merger state mirrored by the bench
    logic        open_q      = 1'b0;
    logic [31:0] end_q       = '0;
    logic [31:0] span_q      = '0;
    logic [6:0]  tables_cnt  = '0;
    logic [63:0] seen_q      = '0;
    logic [6:0]  best_cnt    = '0;

    shim_in_t    pending_hits[$];
    shim_out_t   expected_contigs[$];
    shim_out_t   want;

    logic        idle_on     = 1'b1;
    int          send_wait   = 0;
    int          rcv_wait    = 0;
    int          hold_cycles;
    int          contigs_seen = 0;
    int          fail_count  = 0;
    int          queued_total = 0;
    int          quiet_cycles = 0;

    sorted_hit_interval_merger_top uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    // ------------------------------------------------------------------------
    // contig prediction
    // ------------------------------------------------------------------------
    function automatic void mark_table(input logic [5:0] tid);
        if (tid < NUM_TABLES && !seen_q[tid]) begin
            tables_cnt = tables_cnt + 7'd1;
            seen_q[tid] = 1'b1;
        end
    endfunction

    // Filter the open contig, raise the best count and build its record.
    function automatic shim_out_t close_contig_rec(input logic strand,
                                                   input logic [15:0] rlen);
        shim_out_t   r;
        logic        ok;
        logic [32:0] first;
        logic [33:0] total;
        ok = (span_q <= max_len_q) && (tables_cnt >= min_hits_q)
            && (({1'b0, tables_cnt} + {1'b0, best_dist_q}) >= {1'b0, best_cnt});
        if (ok && tables_cnt > best_cnt) best_cnt = tables_cnt;
        first = {1'b0, end_q} - {1'b0, span_q} + 33'd1;
        first = (first >= {17'b0, pad_q}) ? first - {17'b0, pad_q} : 33'd0;
        total = {2'b0, span_q} + {17'b0, pad_q, 1'b0} + {18'b0, rlen};
        r.contig_start  = first[32] ? '1 : first[31:0];
        r.contig_len    = (total[33:32] != 2'b00) ? '1 : total[31:0];
        r.hit_count     = tables_cnt;
        r.contig_strand = strand;
        r.passed        = ok;
        r.last          = 1'b0;
        return r;
    endfunction

    task automatic merge_hit(input shim_in_t h);
        logic [15:0] lm1;
        logic [31:0] hend;
        logic [32:0] sum;
        shim_out_t   held;
        logic        have;
        have = 1'b0;
        held = '0;
        lm1 = (h.hit_len == 16'd0) ? 16'd0 : h.hit_len - 16'd1;
        sum = {1'b0, h.hit_pos} + {17'b0, lm1};
        hend = sum[32] ? '1 : sum[31:0];
        if (h.new_read) best_cnt = '0;
        if (open_q && h.hit_pos <= end_q) begin
            if (end_q < hend) begin
                sum = {1'b0, span_q} + {1'b0, hend - end_q};
                span_q = sum[32] ? '1 : sum[31:0];
                end_q = hend;
            end
            mark_table(h.table_id);
        end else begin
            if (open_q) begin
                held = close_contig_rec(h.strand, h.read_len);
                have = 1'b1;
            end
            open_q = 1'b1;
            span_q = {16'b0, lm1};
            end_q = hend;
            tables_cnt = '0;
            seen_q = '0;
            mark_table(h.table_id);
        end
        if (h.last_hit) begin
            if (have) expected_contigs = {expected_contigs, held};
            held = close_contig_rec(h.strand, h.read_len);
            have = 1'b1;
            open_q = 1'b0;
            end_q = '0;
            span_q = '0;
            tables_cnt = '0;
            seen_q = '0;
        end
        if (have) begin
            held.last = 1'b1;
            expected_contigs = {expected_contigs, held};
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) merge_hit(s_data);
    end

    // ------------------------------------------------------------------------
    // hit driver
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            send_wait <= 0;
        end else if (!s_valid || s_ready) begin
            if (send_wait != 0) begin
                s_valid <= 1'b0;
                send_wait <= send_wait - 1;
            end else if (pending_hits.size() != 0) begin
                s_data <= pending_hits.pop_front();
                s_valid <= 1'b1;
                send_wait <= idle_on ? int'($urandom_range(0, 9)) : 0;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // contig record monitor
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            rcv_wait <= 0;
        end else if (m_valid && m_ready) begin
            if (expected_contigs.size() == 0) begin
                $error("contig record with none expected: start %0h len %0h",
                       m_data.contig_start, m_data.contig_len);
                fail_count = fail_count + 1;
            end else begin
                want = expected_contigs.pop_front();
                if (m_data.contig_start !== want.contig_start) begin
                    $error("contig_start: expected %0h, got %0h",
                           want.contig_start, m_data.contig_start);
                    fail_count = fail_count + 1;
                end
                if (m_data.contig_len !== want.contig_len) begin
                    $error("contig_len: expected %0h, got %0h",
                           want.contig_len, m_data.contig_len);
                    fail_count = fail_count + 1;
                end
                if (m_data.hit_count !== want.hit_count) begin
                    $error("hit_count: expected %0d, got %0d",
                           want.hit_count, m_data.hit_count);
                    fail_count = fail_count + 1;
                end
                if (m_data.contig_strand !== want.contig_strand) begin
                    $error("contig_strand: expected %0b, got %0b",
                           want.contig_strand, m_data.contig_strand);
                    fail_count = fail_count + 1;
                end
                if (m_data.passed !== want.passed) begin
                    $error("passed: expected %0b, got %0b", want.passed, m_data.passed);
                    fail_count = fail_count + 1;
                end
                if (m_data.last !== want.last) begin
                    $error("last: expected %0b, got %0b", want.last, m_data.last);
                    fail_count = fail_count + 1;
                end
            end
            contigs_seen = contigs_seen + 1;
            // hold off long enough for the block to back up into the input
            if (contigs_seen == 60 || contigs_seen == 240) begin
                hold_cycles = LONG_HOLD;
            end else begin
                hold_cycles = idle_on ? int'($urandom_range(0, 9)) : 0;
            end
            rcv_wait <= hold_cycles;
            m_ready <= (hold_cycles == 0);
        end else if (rcv_wait > 1) begin
            rcv_wait <= rcv_wait - 1;
            m_ready <= 1'b0;
        end else begin
            rcv_wait <= 0;
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    function automatic shim_in_t pack_hit(input logic [31:0] pos, input logic [15:0] len,
                                          input logic [5:0] tid, input logic strand,
                                          input logic [15:0] rlen, input logic nr,
                                          input logic lst);
        shim_in_t h;
        h.hit_pos  = pos;
        h.hit_len  = len;
        h.table_id = tid;
        h.strand   = strand;
        h.read_len = rlen;
        h.new_read = nr;
        h.last_hit = lst;
        return h;
    endfunction

    task automatic queue_hit(input shim_in_t h);
        pending_hits = {pending_hits, h};
        queued_total = queued_total + 1;
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_MAX_CONTIG_LEN: max_len_q = val;
            CFG_MIN_HITS:       min_hits_q = val[6:0];
            CFG_BEST_DISTANCE:  best_dist_q = val[6:0];
            CFG_PADDING:        pad_q = val[15:0];
            default: ;
        endcase
    endtask

    // Hold the sender until every queued hit is in and every record is out.
    task automatic wait_drained();
        @(posedge aclk);
        while (pending_hits.size() != 0 || s_valid || expected_contigs.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // One read: one or two sorted passes, each closed by its last hit.
    task automatic add_read();
        int          passes;
        int          n;
        int          k;
        int          s;
        logic        dense;
        logic [32:0] p;
        logic [15:0] rlen;
        logic [15:0] len;
        logic [5:0]  tid;
        logic        strand;
        rlen = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 300));
        passes = $urandom_range(1, 2);
        for (s = 0; s < passes; s++) begin
            dense = ($urandom_range(0, 29) == 0);
            n = dense ? $urandom_range(64, 72) : $urandom_range(1, 8);
            case ($urandom_range(0, 3))
                0: p = 33'($urandom_range(0, 1000));
                1: p = 33'(32'hFFFF_FFFF - $urandom_range(0, 200000));
                default: p = {1'b0, 32'($urandom)};
            endcase
            for (k = 0; k < n; k++) begin
                if (k > 0) begin
                    if (dense) p = p + $urandom_range(0, 2);
                    else if ($urandom_range(0, 3) == 0) p = p + $urandom_range(60, 70000);
                    else p = p + $urandom_range(0, 50);
                end
                if (p[32]) p = 33'h0_FFFF_FFFF;
                if (dense) len = 16'($urandom_range(4, 64));
                else if ($urandom_range(0, 19) == 0) len = 16'd0;
                else if ($urandom_range(0, 9) == 0) len = 16'($urandom);
                else len = 16'($urandom_range(1, 64));
                if (dense && k < 64) tid = 6'(k);
                else if ($urandom_range(0, 1) == 0) tid = 6'($urandom_range(0, 7));
                else tid = 6'($urandom_range(0, 63));
                strand = s[0];
                if ($urandom_range(0, 19) == 0) strand = !strand;
                if ($urandom_range(0, 29) == 0) rlen = 16'($urandom);
                queue_hit(pack_hit(p[31:0], len, tid, strand, rlen,
                                   (s == 0 && k == 0), (k == n - 1)));
            end
        end
    endtask

    initial begin : stimulus
        int ph;
        int target;
        aresetn = 1'b0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // register defaults: merging, touching, zero length, unsorted,
        // two closes in one step with a strand and read length change
        queue_hit(pack_hit(32'd100, 16'd10, 6'd0, 1'b0, 16'd100, 1'b1, 1'b0));
        queue_hit(pack_hit(32'd105, 16'd10, 6'd0, 1'b0, 16'd100, 1'b0, 1'b0));
        queue_hit(pack_hit(32'd114, 16'd1, 6'd63, 1'b0, 16'd100, 1'b0, 1'b0));
        queue_hit(pack_hit(32'd200, 16'd0, 6'd5, 1'b0, 16'd100, 1'b0, 1'b0));
        queue_hit(pack_hit(32'd150, 16'd5, 6'd6, 1'b0, 16'd100, 1'b0, 1'b0));
        queue_hit(pack_hit(32'd300, 16'hFFFF, 6'd7, 1'b1, 16'hFFFF, 1'b0, 1'b1));
        queue_hit(pack_hit(32'd0, 16'd1, 6'd1, 1'b0, 16'd0, 1'b1, 1'b1));
        // end past the top, then a one-base hit at the very top
        queue_hit(pack_hit(32'hFFFF_FFF0, 16'hFFFF, 6'd2, 1'b0, 16'd7, 1'b0, 1'b0));
        queue_hit(pack_hit(32'hFFFF_FFFF, 16'd100, 6'd3, 1'b0, 16'd7, 1'b0, 1'b1));
        queue_hit(pack_hit(32'hFFFF_FFFF, 16'd1, 6'd4, 1'b1, 16'd7, 1'b0, 1'b1));
        // new read while a contig is open
        queue_hit(pack_hit(32'd10, 16'd5, 6'd9, 1'b0, 16'd50, 1'b1, 1'b0));
        queue_hit(pack_hit(32'd12, 16'd3, 6'd10, 1'b0, 16'd50, 1'b1, 1'b0));
        queue_hit(pack_hit(32'd13, 16'd1, 6'd11, 1'b0, 16'd50, 1'b0, 1'b1));
        // best count: a strong contig, then a weak one in the same read
        queue_hit(pack_hit(32'd1000, 16'd20, 6'd1, 1'b0, 16'd30, 1'b1, 1'b0));
        queue_hit(pack_hit(32'd1002, 16'd20, 6'd2, 1'b0, 16'd30, 1'b0, 1'b0));
        queue_hit(pack_hit(32'd1004, 16'd20, 6'd3, 1'b0, 16'd30, 1'b0, 1'b0));
        queue_hit(pack_hit(32'd5000, 16'd4, 6'd4, 1'b0, 16'd30, 1'b0, 1'b1));
        queue_hit(pack_hit(32'hFFFF_FFFF, 16'hFFFF, 6'd63, 1'b1, 16'hFFFF, 1'b1, 1'b1));
        wait_drained();

        // tightest filters and widest padding
        write_reg(CFG_MAX_CONTIG_LEN, 32'd0);
        write_reg(CFG_MIN_HITS, 32'd64);
        write_reg(CFG_BEST_DISTANCE, 32'd0);
        write_reg(CFG_PADDING, 32'd65535);
        queue_hit(pack_hit(32'd10, 16'd1, 6'd0, 1'b0, 16'hFFFF, 1'b1, 1'b1));
        queue_hit(pack_hit(32'd70000, 16'd1, 6'd1, 1'b1, 16'd0, 1'b0, 1'b0));
        queue_hit(pack_hit(32'd70000, 16'd1, 6'd2, 1'b1, 16'd0, 1'b0, 1'b0));
        queue_hit(pack_hit(32'd80000, 16'd9, 6'd3, 1'b1, 16'd0, 1'b0, 1'b1));
        queue_hit(pack_hit(32'hFFFF_0000, 16'd3, 6'd3, 1'b0, 16'd1, 1'b0, 1'b1));

        for (ph = 0; ph < 6; ph++) begin
            wait_drained();
            if (ph == 0) begin
                write_reg(CFG_MAX_CONTIG_LEN, 32'hFFFF_FFFF);
                write_reg(CFG_MIN_HITS, 32'd0);
                write_reg(CFG_BEST_DISTANCE, 32'd64);
                write_reg(CFG_PADDING, 32'd0);
            end else begin
                case ($urandom_range(0, 3))
                    0: write_reg(CFG_MAX_CONTIG_LEN, 32'd0);
                    1: write_reg(CFG_MAX_CONTIG_LEN, $urandom_range(0, 2000));
                    2: write_reg(CFG_MAX_CONTIG_LEN, $urandom_range(0, 100000));
                    default: write_reg(CFG_MAX_CONTIG_LEN, 32'hFFFF_FFFF);
                endcase
                write_reg(CFG_MIN_HITS, ($urandom_range(0, 5) == 0) ? 32'd64
                                                                   : $urandom_range(0, 4));
                write_reg(CFG_BEST_DISTANCE, ($urandom_range(0, 3) == 0) ? 32'd64
                                                                        : $urandom_range(0, 3));
                case ($urandom_range(0, 2))
                    0: write_reg(CFG_PADDING, $urandom_range(0, 200));
                    1: write_reg(CFG_PADDING, 32'd65535);
                    default: write_reg(CFG_PADDING, $urandom_range(0, 65535));
                endcase
            end
            @(posedge aclk);
            idle_on <= (ph != 2);
            target = queued_total + PHASE_ITEMS;
            while (queued_total < target) begin
                if ($urandom_range(0, 7) == 0) begin
                    // noise: anything the fields allow
                    queue_hit(pack_hit($urandom, 16'($urandom), 6'($urandom),
                                       1'($urandom), 16'($urandom), 1'($urandom),
                                       1'($urandom)));
                end else begin
                    add_read();
                end
            end
        end

        wait_drained();
        repeat (10) @(posedge aclk);
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
